/* src/smx_pkg.sv */
`default_nettype none
package smx_pkg;

  // Vector geometry
  localparam int MAX_LEN = 64;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  // Field and datapath widths
  localparam int SCORE_W = 16;
  localparam int PROB_W  = 16;
  localparam int TERM_W  = 16;
  localparam int SUM_W   = 22;
  localparam int NUM_W   = 32;

  // log2(e) in Q.16
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  // Serial divider: quotient never exceeds 2^16, so 17 steps cover it
  localparam int DIV_STEPS = 17;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Controller states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SUM_ISSUE,
    ST_SUM_DRAIN,
    ST_EMIT_ISSUE,
    ST_EMIT_EXP,
    ST_EMIT_DIV
  } smx_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_en;
    logic idx_clr;
    logic idx_inc;
    logic rd_en;
    logic sum_clr;
    logic sum_mode;
    logic div_start;
    logic out_load;
    logic vec_clr;
  } smx_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic idx_last;
    logic pipe_idle;
    logic term_valid;
    logic div_busy;
    logic out_free;
  } smx_sts_t;

  // 2^(-i/16) in Q1.16, i = 0..16
  function automatic logic [16:0] pow2_tab(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* src/smx_exp.sv */
`default_nettype none
// Three-stage exponential: exp(score - max) as 2^(-t*log2e), Q1.15 result
module smx_exp
  import smx_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic signed [SCORE_W-1:0] score,
  input  wire logic signed [SCORE_W-1:0] max_score,
  output logic                           term_valid,
  output logic [TERM_W-1:0]              term,
  output logic                           idle
);

  logic              v1_r, v2_r, v3_r;
  logic [32:0]       prod_r;
  logic [11:0]       dr_hi_r;
  logic [16:0]       ti_r;
  logic [3:0]        n_r;
  logic              zero_r;
  logic [TERM_W-1:0] term_r;

  logic [15:0] t;
  logic [24:0] y;
  logic [4:0]  ti_idx;
  logic [16:0] t_lo;
  logic [16:0] t_hi;
  logic [11:0] diff;
  logic [23:0] dr;
  logic [16:0] m;
  logic [4:0]  sh;
  logic [16:0] m_sh;

  // Stage 1: distance below max, scale by log2(e)
  always_comb begin
    t = 16'(max_score - score);
  end

  // Stage 2: split exponent, interpolate between table points
  always_comb begin
    y      = prod_r[32:8];
    ti_idx = {1'b0, y[15:12]};
    t_lo   = pow2_tab(ti_idx);
    t_hi   = pow2_tab(ti_idx + 5'd1);
    diff   = 12'(t_lo - t_hi);
    dr     = diff * y[11:0];
  end

  // Stage 3: apply integer part of exponent as a right shift
  always_comb begin
    m    = ti_r - {5'd0, dr_hi_r};
    sh   = {1'b0, n_r} + 5'd1;
    m_sh = m >> sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= t * LOG2E_Q16;
    dr_hi_r <= dr[23:12];
    ti_r    <= t_lo;
    n_r     <= y[19:16];
    zero_r  <= (y[24:20] != 5'd0);
    term_r  <= zero_r ? '0 : TERM_W'(m_sh);
  end

  assign term_valid = v3_r;
  assign term       = term_r;
  assign idle       = !(v1_r || v2_r || v3_r);

endmodule
`default_nettype wire

/* src/smx_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle, saturating to 16 bits
module smx_div
  import smx_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [NUM_W-1:0]   num,
  input  wire logic [SUM_W-1:0]   den,
  output logic                    busy,
  output logic [PROB_W-1:0]       quot
);

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0]     rem_r, rem_nxt;
  logic [DIV_STEPS-1:0] sh_r, sh_nxt;
  logic [SUM_W-1:0]     den_r, den_nxt;
  logic [SUM_W:0]       trial;
  logic                 ge;

  // Operand load on start, else one subtract-and-compare step
  always_comb begin
    trial    = {rem_r, sh_r[DIV_STEPS-1]};
    ge       = (trial >= {1'b0, den_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = SUM_W'(num[NUM_W-1:DIV_STEPS]);
      sh_nxt   = num[DIV_STEPS-1:0];
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? SUM_W'(trial - {1'b0, den_r}) : trial[SUM_W-1:0];
      sh_nxt  = {sh_r[DIV_STEPS-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign quot = sh_r[DIV_STEPS-1] ? {PROB_W{1'b1}} : sh_r[PROB_W-1:0];

endmodule
`default_nettype wire

/* src/smx_datapath.sv */
`default_nettype none
// Score store, running max, element count, exp sum, divider and output register
module smx_datapath
  import smx_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire smx_cmd_t           cmd,
  output smx_sts_t                sts,
  input  wire logic [SCORE_W-1:0] in_score,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [PROB_W-1:0]       out_prob,
  output logic                    out_last
);

  logic [SCORE_W-1:0] mem [MAX_LEN];

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic signed [SCORE_W-1:0] max_r, max_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic                      rd_valid_r;
  logic signed [SCORE_W-1:0] rd_data_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [PROB_W-1:0]         out_prob_r;
  logic                      out_last_r;

  logic              room;
  logic              idx_last;
  logic              term_valid;
  logic [TERM_W-1:0] term;
  logic              exp_idle;
  logic              div_busy;
  logic [PROB_W-1:0] quot;
  logic [NUM_W-1:0]  num;

  assign room     = (count_r != CNT_W'(MAX_LEN));
  assign idx_last = ((CNT_W'(idx_r) + 1'b1) == count_r);

  // Store scores as they arrive and read them back by index
  always_ff @(posedge clk) begin
    if (cmd.load_en && room) begin
      mem[count_r[IDX_W-1:0]] <= in_score;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[idx_r];
    end
  end

  // Count, max, read index, sum, output flag
  always_comb begin
    count_nxt     = count_r;
    max_nxt       = max_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    if (cmd.load_en && room) begin
      count_nxt = count_r + 1'b1;
      if ($signed(in_score) > max_r) begin
        max_nxt = $signed(in_score);
      end
    end
    if (cmd.vec_clr) begin
      count_nxt = '0;
      max_nxt   = {1'b1, {(SCORE_W-1){1'b0}}};
    end
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (cmd.sum_clr) begin
      sum_nxt = '0;
    end else if (cmd.sum_mode && term_valid) begin
      sum_nxt = sum_r + SUM_W'(term);
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      max_r       <= {1'b1, {(SCORE_W-1){1'b0}}};
      idx_r       <= '0;
      sum_r       <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      max_r       <= max_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      rd_valid_r  <= cmd.rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_prob_r <= quot;
      out_last_r <= idx_last;
    end
  end

  smx_exp u_exp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (rd_valid_r),
    .score      (rd_data_r),
    .max_score  (max_r),
    .term_valid (term_valid),
    .term       (term),
    .idle       (exp_idle)
  );

  // Numerator: term scaled to Q.16 plus half the sum for rounding
  assign num = {term, 16'd0} + NUM_W'(sum_r[SUM_W-1:1]);

  smx_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (sum_r),
    .busy  (div_busy),
    .quot  (quot)
  );

  always_comb begin
    sts.idx_last   = idx_last;
    sts.pipe_idle  = exp_idle && !rd_valid_r;
    sts.term_valid = term_valid;
    sts.div_busy   = div_busy;
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_prob  = out_prob_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

/* src/smx_ctrl.sv */
`default_nettype none
// Sequencer: load scores, sum pass, then one probability at a time
module smx_ctrl
  import smx_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_last,
  output logic          in_ready,
  input  wire smx_sts_t sts,
  output smx_cmd_t      cmd
);

  smx_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_en = 1'b1;
          if (in_last) begin
            cmd.idx_clr = 1'b1;
            cmd.sum_clr = 1'b1;
            state_nxt   = ST_SUM_ISSUE;
          end
        end
      end
      // Stream every stored score through the exp pipeline
      ST_SUM_ISSUE: begin
        cmd.sum_mode = 1'b1;
        cmd.rd_en    = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = ST_SUM_DRAIN;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_SUM_DRAIN: begin
        cmd.sum_mode = 1'b1;
        if (sts.pipe_idle) begin
          state_nxt = ST_EMIT_ISSUE;
        end
      end
      ST_EMIT_ISSUE: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_EMIT_EXP;
      end
      ST_EMIT_EXP: begin
        if (sts.term_valid) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_EMIT_DIV;
        end
      end
      // Hand the quotient to the output register once the divider is done and it is free
      ST_EMIT_DIV: begin
        if (!sts.div_busy && sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.idx_last) begin
            cmd.vec_clr = 1'b1;
            state_nxt   = ST_LOAD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ST_EMIT_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/softmax_vector_core.sv */
`default_nettype none
// Channel   Direction  Handshake          Payload
// in_       input      tvalid / tready    tdata = score (Q8.8), tlast = last score
// out_      output     tvalid / tready    tdata = probability (Q0.16), tlast = last one
//
// Scores load at one per cycle into a 64-entry store; a score beyond 64 is dropped.
// After the last score a sum pass streams every stored score through the exp pipeline.
// Each probability then goes through a store read, the exp pipeline, the 17-step
// serial divider and a load into the output register.
// Reset is synchronous, active low; the store needs no clearing.
// Output stalls hold the divider result; the next vector may load while the
// final probability still waits in the output register.
module softmax_vector_core
  import smx_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [SCORE_W-1:0] in_tdata,   // [15:0] score
  input  wire logic               in_tlast,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [PROB_W-1:0]       out_tdata,  // [15:0] probability
  output logic                    out_tlast
);

  smx_cmd_t cmd;
  smx_sts_t sts;

  smx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  smx_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_score  (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_prob  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule
`default_nettype wire
